// File: src/pidpc_pkg.sv
// pidpc_pkg: shared constants and types for the PID position controller.
// Holds default parameter values, register indexes and fixed field widths.
// Depends on nothing; compile first.
package pidpc_pkg;

  localparam int POSITION_BITS_DEF  = 24;
  localparam int GAIN_FRAC_BITS_DEF = 8;
  localparam int INTEGRAL_BITS_DEF  = 40;

  localparam int GAIN_W     = 16;
  localparam int DRIVE_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // integral clears once the proportional term reaches this, in whole units
  localparam int CLEAR_LIMIT = 127;

  // magnitude limit on each gain product
  localparam longint TERM_LIMIT = 64'sd1 <<< 60;

  localparam longint DRIVE_MAX = 64'sd2147483647;
  localparam longint DRIVE_MIN = -64'sd2147483648;

  typedef logic [GAIN_W-1:0]    gain_t;
  typedef logic [CFG_IDX_W-1:0] cfg_index_t;

  localparam cfg_index_t REG_GAIN_P   = 2'd0;
  localparam cfg_index_t REG_GAIN_I   = 2'd1;
  localparam cfg_index_t REG_GAIN_D   = 2'd2;
  localparam cfg_index_t REG_FEEDBACK = 2'd3;

endpackage

// File: src/pid_position_controller.sv
// pid_position_controller: position PID loop with derivative on measurement.
// Five register stages (input, error/P, integral/D, I, drive); the middle three
// hold one multiply each.
// Depends on pidpc_pkg for defaults, register indexes and limits.
//
// An accepted input beat goes through stages A, B, C and the drive register to out_tvalid.
// Throughput: one beat per cycle unless out_tready stalls; no stage holds two multiplies.
// Stages advance on their own, so empty slots fill even while a drive beat waits.
// Reset (rst_n low, synchronous): clears all stage valids, gains, feedback flag,
// the integral accumulator and the last position.
module pid_position_controller #(
  parameter int POSITION_BITS  = pidpc_pkg::POSITION_BITS_DEF,
  parameter int GAIN_FRAC_BITS = pidpc_pkg::GAIN_FRAC_BITS_DEF,
  parameter int INTEGRAL_BITS  = pidpc_pkg::INTEGRAL_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // input stream
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // fields from bit 0: setpoint, measured_position, zero pad
  input  logic [((2*POSITION_BITS+7)/8)*8-1:0]   in_tdata,
  // result stream
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // fields from bit 0: drive
  output logic [pidpc_pkg::DRIVE_W-1:0]          out_tdata,
  // configuration write channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  pidpc_pkg::cfg_index_t                  cfg_index,
  input  logic [pidpc_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import pidpc_pkg::*;

  // widths
  localparam int EW   = POSITION_BITS + 1;              // error and position delta
  localparam int PPW  = EW + GAIN_W + 1;                // P and D product
  localparam int IPW  = INTEGRAL_BITS + GAIN_W + 1;     // I product
  localparam int PMAX = (PPW > IPW) ? PPW : IPW;
  localparam int CW   = (PMAX > 62) ? PMAX : 62;        // compare width for the term limit
  localparam int TW   = (PMAX > 62) ? 62 : PMAX;        // limited term width
  localparam int PDW  = TW + 1;                         // P plus D
  localparam int SUMW = TW + 2;                         // full sum
  localparam int AW   = ((INTEGRAL_BITS > EW) ? INTEGRAL_BITS : EW) + 1;

  localparam logic signed [CW-1:0]   TERM_HI = CW'(TERM_LIMIT);
  localparam logic signed [CW-1:0]   TERM_LO = -TERM_HI;
  localparam logic signed [TW-1:0]   CLEAR_Q = TW'(longint'(CLEAR_LIMIT) <<< GAIN_FRAC_BITS);
  localparam logic signed [AW-1:0]   IMAX =
    {{(AW-INTEGRAL_BITS+1){1'b0}}, {(INTEGRAL_BITS-1){1'b1}}};
  localparam logic signed [AW-1:0]   IMIN = ~IMAX;
  localparam logic signed [SUMW-1:0] RND  = SUMW'((longint'(1) <<< GAIN_FRAC_BITS) - 1);
  localparam logic signed [SUMW-1:0] OMAX = SUMW'(DRIVE_MAX);
  localparam logic signed [SUMW-1:0] OMIN = SUMW'(DRIVE_MIN);

  // clamp a gain product to the term limit and narrow it
  function automatic logic signed [TW-1:0] limit_term(input logic signed [CW-1:0] p);
    logic signed [CW-1:0] t;
    begin
      t = p;
      if (p > TERM_HI) t = TERM_HI;
      if (p < TERM_LO) t = TERM_LO;
      return TW'(t);
    end
  endfunction

  // configuration registers
  gain_t gain_p_r, gain_i_r, gain_d_r;
  logic  fb_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= '0;
      gain_i_r <= '0;
      gain_d_r <= '0;
      fb_r     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GAIN_P:   gain_p_r <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:   gain_i_r <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:   gain_d_r <= cfg_data[GAIN_W-1:0];
        REG_FEEDBACK: fb_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // stage valids and advance enables; a stage loads when empty or draining
  logic v0_r, va_r, vb_r, vc_r, out_v_r;
  logic en_0, en_a, en_b, en_c, en_out;

  assign en_out = !out_v_r || out_tready;
  assign en_c   = !vc_r || en_out;
  assign en_b   = !vb_r || en_c;
  assign en_a   = !va_r || en_b;
  assign en_0   = !v0_r || en_a;

  assign in_tready  = en_0;
  assign out_tvalid = out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r    <= 1'b0;
      va_r    <= 1'b0;
      vb_r    <= 1'b0;
      vc_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (en_0)   v0_r    <= in_tvalid;
      if (en_a)   va_r    <= v0_r;
      if (en_b)   vb_r    <= va_r;
      if (en_c)   vc_r    <= vb_r;
      if (en_out) out_v_r <= vc_r;
    end
  end

  // input register: capture the beat as it stands
  logic signed [POSITION_BITS-1:0] sp_r, pos_r;

  always_ff @(posedge clk) begin
    if (en_0 && in_tvalid) begin
      sp_r  <= $signed(in_tdata[POSITION_BITS-1:0]);
      pos_r <= $signed(in_tdata[2*POSITION_BITS-1:POSITION_BITS]);
    end
  end

  // stage A: error, proportional product, position delta
  logic signed [POSITION_BITS-1:0] last_pos_r;
  logic signed [EW-1:0]            err_c, dpos_c, err_r, dpos_r;
  logic signed [PPW-1:0]           pprod;
  logic signed [TW-1:0]            pterm_r;

  assign err_c  = EW'(sp_r) - EW'(pos_r);
  assign dpos_c = EW'(pos_r) - EW'(last_pos_r);
  assign pprod  = $signed({1'b0, gain_p_r}) * err_c;

  always_ff @(posedge clk) begin
    if (en_a && v0_r) begin
      err_r   <= err_c;
      dpos_r  <= dpos_c;
      pterm_r <= limit_term(CW'(pprod));
    end
  end

  // last position advances only with feedback present
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pos_r <= '0;
    end else if (en_a && v0_r && fb_r) begin
      last_pos_r <= pos_r;
    end
  end

  // stage B: integral update (state and stage payload in one), derivative product
  logic signed [INTEGRAL_BITS-1:0] integral_sum_r, integral_nxt;
  logic signed [AW-1:0]            isum_c;
  logic                            clear_c;
  logic signed [PPW-1:0]           dprod;
  logic signed [TW-1:0]            pterm_b_r, dterm_b_r;

  assign clear_c = (err_r == '0) || (pterm_r >= CLEAR_Q);
  assign isum_c  = AW'(integral_sum_r) + AW'(err_r);
  assign dprod   = $signed({1'b0, gain_d_r}) * dpos_r;

  always_comb begin
    if (clear_c) begin
      integral_nxt = '0;
    end else if (isum_c > IMAX) begin
      integral_nxt = INTEGRAL_BITS'(IMAX);
    end else if (isum_c < IMIN) begin
      integral_nxt = INTEGRAL_BITS'(IMIN);
    end else begin
      integral_nxt = INTEGRAL_BITS'(isum_c);
    end
  end

  // hold the accumulator while feedback is absent
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_sum_r <= '0;
    end else if (en_b && va_r && fb_r) begin
      integral_sum_r <= integral_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b && va_r) begin
      pterm_b_r <= pterm_r;
      dterm_b_r <= limit_term(CW'(dprod));
    end
  end

  // stage C: integral product, fold P and D
  logic signed [IPW-1:0] iprod;
  logic signed [TW-1:0]  iterm_r;
  logic signed [PDW-1:0] pd_r;

  assign iprod = $signed({1'b0, gain_i_r}) * integral_sum_r;

  always_ff @(posedge clk) begin
    if (en_c && vb_r) begin
      iterm_r <= limit_term(CW'(iprod));
      pd_r    <= PDW'(pterm_b_r) + PDW'(dterm_b_r);
    end
  end

  // output stage: total, truncate toward zero, saturate to drive width; zero if no feedback
  logic signed [SUMW-1:0]    sum_c, q_c;
  logic signed [DRIVE_W-1:0] drive_nxt, drive_r;

  assign sum_c = SUMW'(pd_r) + SUMW'(iterm_r);
  assign q_c   = $signed(sum_c + (sum_c[SUMW-1] ? RND : '0)) >>> GAIN_FRAC_BITS;

  always_comb begin
    if (!fb_r) begin
      drive_nxt = '0;
    end else if (q_c > OMAX) begin
      drive_nxt = DRIVE_W'(OMAX);
    end else if (q_c < OMIN) begin
      drive_nxt = DRIVE_W'(OMIN);
    end else begin
      drive_nxt = DRIVE_W'(q_c);
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && vc_r) begin
      drive_r <= drive_nxt;
    end
  end

  assign out_tdata = drive_r;

  // a zero error with feedback clears the accumulator on the next edge
  a_zero_err_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (en_b && va_r && fb_r && err_r == '0) |=> integral_sum_r == '0)
    else $error("integral not cleared on zero error");

  // last position moves only when a beat enters stage A
  a_last_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(en_a && v0_r) |=> $stable(last_pos_r))
    else $error("last position changed without a beat");

  // a stalled stage C keeps its item
  a_stage_c_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (vc_r && !en_c) |=> vc_r)
    else $error("stage C item lost under stall");

  // a taken drive beat with nothing behind it leaves the output empty
  a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_tready && !vc_r) |=> !out_v_r)
    else $error("drive beat repeated");

endmodule
